### sv/bfm_pkg.sv
`default_nettype none
package bfm_pkg;

	// Filter geometry and key limits
	localparam int FILTER_BITS   = 65536;
	localparam int MAX_HASHES    = 8;
	localparam int MAX_KEY_BYTES = 256;

	localparam int WORD_W   = 32;
	localparam int ROWS     = FILTER_BITS / WORD_W;
	localparam int ROW_W    = $clog2(ROWS);
	localparam int BIT_W    = $clog2(WORD_W);
	localparam int IDX_W    = $clog2(FILTER_BITS);
	localparam int HSEL_W   = $clog2(MAX_HASHES);
	localparam int CNT_W    = $clog2(MAX_KEY_BYTES) + 1;
	localparam int NH_W     = 4;
	localparam int RANGE_W  = 17;
	localparam int DIVC_W   = 5;

	// Configuration register indexes
	localparam logic REG_NUM_HASHES  = 1'b0;
	localparam logic REG_INDEX_RANGE = 1'b1;

	// MurmurHash3 constants
	localparam logic [31:0] MM_C1 = 32'hCC9E2D51;
	localparam logic [31:0] MM_C2 = 32'h1B873593;
	localparam logic [31:0] MM_N  = 32'hE6546B64;
	localparam logic [31:0] MM_F1 = 32'h85EBCA6B;
	localparam logic [31:0] MM_F2 = 32'hC2B2AE35;

	typedef struct packed {
		logic       cmd;
		logic [7:0] key_byte;
		logic       last;
	} bfm_in_t;

	typedef struct packed {
		logic present;
		logic was_test;
		logic key_too_long;
	} bfm_out_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_BLK1, S_BLK2, S_LANES, S_TL1, S_TL2,
		S_FM1, S_FM2, S_FM3, S_DIV, S_RD, S_RMW, S_DONE
	} bfm_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clr_wr;
		logic take;
		logic mix1;
		logic mix2;
		logic lanes;
		logic hash_init;
		logic fm1;
		logic fm2;
		logic fm3;
		logic div_step;
		logic rd;
		logic rmw;
		logic load_out;
	} bfm_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic blk_next;
		logic ovf_next;
		logic in_last;
		logic last_q;
		logic k_zero;
		logic div_last;
		logic hash_last;
		logic out_busy;
	} bfm_sts_t;

endpackage
`default_nettype wire

### sv/bfm_ram.sv
`default_nettype none
module bfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

### sv/bfm_ctrl.sv
`default_nettype none
module bfm_ctrl
	import bfm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire bfm_sts_t   sts,
	output logic            in_ready,
	output bfm_cmd_t        cmd,
	output bfm_state_t      state
);

	bfm_state_t state_q, state_d;
	logic       take;

	assign take  = in_valid && (state_q == S_IDLE);
	assign state = state_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: if (sts.clr_last) state_d = S_IDLE;
			S_IDLE: begin
				if (take) begin
					if (sts.blk_next) state_d = S_BLK1;
					else if (sts.in_last) state_d = sts.ovf_next ? S_DONE : S_TL1;
				end
			end
			S_BLK1:  state_d = S_BLK2;
			S_BLK2:  state_d = S_LANES;
			S_LANES: state_d = sts.last_q ? S_TL1 : S_IDLE;
			S_TL1:   state_d = S_TL2;
			S_TL2:   state_d = sts.k_zero ? S_DONE : S_FM1;
			S_FM1:   state_d = S_FM2;
			S_FM2:   state_d = S_FM3;
			S_FM3:   state_d = S_DIV;
			S_DIV:   if (sts.div_last) state_d = S_RD;
			S_RD:    state_d = S_RMW;
			S_RMW:   state_d = sts.hash_last ? S_DONE : S_FM1;
			S_DONE:  if (!sts.out_busy) state_d = S_IDLE;
			default: state_d = S_CLR;
		endcase
	end

	// Outputs
	always_comb begin
		cmd           = '0;
		in_ready      = (state_q == S_IDLE);
		cmd.take      = take;
		cmd.clr_wr    = (state_q == S_CLR);
		cmd.mix1      = (state_q == S_BLK1) || (state_q == S_TL1);
		cmd.mix2      = (state_q == S_BLK2) || (state_q == S_TL2);
		cmd.lanes     = (state_q == S_LANES);
		cmd.hash_init = (state_q == S_TL2);
		cmd.fm1       = (state_q == S_FM1);
		cmd.fm2       = (state_q == S_FM2);
		cmd.fm3       = (state_q == S_FM3);
		cmd.div_step  = (state_q == S_DIV);
		cmd.rd        = (state_q == S_RD);
		cmd.rmw       = (state_q == S_RMW);
		cmd.load_out  = (state_q == S_DONE) && !sts.out_busy;
	end

endmodule
`default_nettype wire

### sv/bfm_dp.sv
`default_nettype none
module bfm_dp
	import bfm_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic            cfg_idx,
	input  wire logic [16:0]     cfg_wdata,
	input  wire bfm_in_t         in_data,
	input  wire logic            out_ready,
	input  wire bfm_cmd_t        cmd,
	output bfm_sts_t             sts,
	output logic                 out_valid,
	output bfm_out_t             out_data,
	output logic                 ram_we
);

	logic [NH_W-1:0]    num_hashes_q;
	logic [RANGE_W-1:0] index_range_q;
	logic [31:0]        lane_q [MAX_HASHES];
	logic [31:0]        tail_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q, cmd_q, last_q;
	logic [31:0]        m1_q, kb_q, f1_q, f2_q, dvd_q;
	logic [RANGE_W-1:0] rem_q;
	logic [DIVC_W-1:0]  divc_q;
	logic [HSEL_W-1:0]  hidx_q;
	logic               present_q;
	logic [ROW_W-1:0]   clr_q;
	logic               out_valid_q;
	bfm_out_t           out_q;

	logic [1:0]         pos;
	logic               ovf_next;
	logic [NH_W-1:0]    k;
	logic [RANGE_W-1:0] range;
	logic [31:0]        hx, fa, fb;
	logic [RANGE_W:0]   trial;
	logic [ROW_W-1:0]   ram_addr;
	logic [WORD_W-1:0]  ram_wdata, ram_rdata, bit_mask;

	assign pos      = count_q[1:0];
	assign ovf_next = ovf_q || (count_q >= CNT_W'(MAX_KEY_BYTES));
	assign k        = (num_hashes_q > NH_W'(MAX_HASHES)) ? NH_W'(MAX_HASHES) : num_hashes_q;

	// Saturated modulus
	always_comb begin
		range = index_range_q;
		if (index_range_q == '0) range = RANGE_W'(1);
		else if (index_range_q > RANGE_W'(FILTER_BITS)) range = RANGE_W'(FILTER_BITS);
	end

	assign sts.clr_last  = &clr_q;
	assign sts.blk_next  = !ovf_next && (pos == 2'd3);
	assign sts.ovf_next  = ovf_next;
	assign sts.in_last   = in_data.last;
	assign sts.last_q    = last_q;
	assign sts.k_zero    = (k == '0);
	assign sts.div_last  = &divc_q;
	assign sts.hash_last = (NH_W'(hidx_q) + NH_W'(1)) == k;
	assign sts.out_busy  = out_valid_q && !out_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_hashes_q  <= NH_W'(3);
			index_range_q <= RANGE_W'(65536);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_NUM_HASHES:  num_hashes_q  <= cfg_wdata[NH_W-1:0];
				REG_INDEX_RANGE: index_range_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Per-key state: byte intake, lane update, clearing on result load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_HASHES; i++) lane_q[i] <= 32'(i);
			tail_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			cmd_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			if (cmd.take) begin
				cmd_q  <= in_data.cmd;
				last_q <= in_data.last;
				if (ovf_next) begin
					ovf_q <= 1'b1;
				end else begin
					tail_q  <= tail_q | (32'(in_data.key_byte) << {pos, 3'b000});
					count_q <= count_q + CNT_W'(1);
				end
			end
			// lane = rotl13(lane ^ kb) * 5 + n, the times five as x + (x << 2)
			if (cmd.lanes) begin
				for (int i = 0; i < MAX_HASHES; i++) begin
					lane_q[i] <= {lane_q[i][18:0] ^ kb_q[18:0], lane_q[i][31:19] ^ kb_q[31:19]}
						+ {lane_q[i][16:0] ^ kb_q[16:0], lane_q[i][31:19] ^ kb_q[31:19],
						2'b00}
						+ MM_N;
				end
				tail_q <= '0;
			end
			if (cmd.load_out) begin
				for (int i = 0; i < MAX_HASHES; i++) lane_q[i] <= 32'(i);
				tail_q  <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
				last_q  <= 1'b0;
			end
		end
	end

	// Block mix, one multiply per cycle
	always_ff @(posedge clk) begin
		if (cmd.mix1) m1_q <= 32'(tail_q * MM_C1);
		if (cmd.mix2) kb_q <= 32'({m1_q[16:0], m1_q[31:17]} * MM_C2);
	end

	// Finalisation of the selected lane
	assign hx = lane_q[hidx_q] ^ ((pos != 2'd0) ? kb_q : 32'd0) ^ 32'(count_q);
	assign fa = hx ^ (hx >> 16);
	assign fb = f1_q ^ (f1_q >> 13);

	always_ff @(posedge clk) begin
		if (cmd.fm1) f1_q <= 32'(fa * MM_F1);
		if (cmd.fm2) f2_q <= 32'(fb * MM_F2);
	end

	// Restoring remainder, one bit per cycle
	assign trial = {rem_q, dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divc_q <= '0;
		end else if (cmd.fm3) begin
			divc_q <= '0;
		end else if (cmd.div_step) begin
			divc_q <= divc_q + DIVC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fm3) begin
			dvd_q <= f2_q ^ (f2_q >> 16);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, range}) rem_q <= RANGE_W'(trial - {1'b0, range});
			else rem_q <= trial[RANGE_W-1:0];
		end
	end

	// Hash sequencing and membership result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidx_q    <= '0;
			present_q <= 1'b0;
		end else if (cmd.hash_init) begin
			hidx_q    <= '0;
			present_q <= 1'b1;
		end else if (cmd.rmw) begin
			hidx_q <= hidx_q + HSEL_W'(1);
			if (!ram_rdata[rem_q[BIT_W-1:0]]) present_q <= 1'b0;
		end
	end

	// Bit store clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + ROW_W'(1);
		end
	end

	assign bit_mask  = WORD_W'(1) << rem_q[BIT_W-1:0];
	assign ram_we    = cmd.clr_wr || (cmd.rmw && !cmd_q);
	assign ram_addr  = cmd.clr_wr ? clr_q : rem_q[IDX_W-1:BIT_W];
	assign ram_wdata = cmd.clr_wr ? '0 : (ram_rdata | bit_mask);

	bfm_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.present      <= !ovf_q && cmd_q && present_q;
			out_q.was_test     <= cmd_q;
			out_q.key_too_long <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

### sv/bloom_filter_murmur_insert_test.sv
// Bloom filter with MurmurHash3 x86_32 hashing, insert and membership test.
// Input channel (in_valid/in_ready/in_data): one key byte per transfer, the
// final byte marked by last; cmd on the final byte picks insert or test.
// Output channel (out_valid/out_ready/out_data): one result per key.
// Configuration: cfg_we writes num_hashes (index 0) or index_range (index 1);
// the user must write only while the block is idle; the block does not enforce it.
// Input: after a byte that does not complete a 4-byte block, the next byte
// can be taken at once; one that does is followed by two mix multiplies,
// then the lane update, before the next byte is taken.
// Key end: the tail mix, then per hash the finalisation, the bit-serial
// remainder unit and a read-modify-write on the single-port bit store, then
// the load of the result register; an oversized key goes straight to the load.
// Reset: a clearing pass writes the 2048 rows of the bit store, one per
// cycle; in_ready stays low until the pass ends.
// A stalled receiver holds the result register; further key bytes are still
// taken, but the next result load waits until the held result is transferred.
`default_nettype none
module bloom_filter_murmur_insert_test
	import bfm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire bfm_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output bfm_out_t         out_data
);

	bfm_cmd_t   cmd;
	bfm_sts_t   sts;
	bfm_state_t state;
	logic       ram_we;

	bfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd),
		.state    (state)
	);

	bfm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data),
		.ram_we    (ram_we)
	);

`ifndef SYNTHESIS
	// No key byte is taken during the clearing pass
	a_no_take_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state == S_CLR |-> !in_ready)
		else $error("input taken during clearing pass");

	// The bit store is written only by the clearing pass or an insert
	a_ram_we: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state == S_CLR || state == S_RMW))
		else $error("unexpected bit store write");

	// A fresh result comes only from the result-loading state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state) == S_DONE)
		else $error("result raised outside DONE");
`endif

endmodule
`default_nettype wire

### tb/tb_bloom_filter_murmur_insert_test.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_bloom_filter_murmur_insert_test;
	import bfm_pkg::*;

	// Clock, reset and block ports
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_idx;
	logic [16:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	bfm_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	bfm_out_t    out_data;

	bloom_filter_murmur_insert_test u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Predictor state: filter contents, per-key hash state and registers
	bit          filt_bits [FILTER_BITS];
	logic [31:0] lane_hash [MAX_HASHES];
	logic [31:0] tail_acc;
	int unsigned key_len;
	bit          key_ovf;
	logic [3:0]  hash_cnt;
	logic [16:0] idx_range;

	bfm_in_t  byte_q [$];
	bfm_out_t verdict_q [$];
	int       n_errors;
	int       n_keys;
	longint   cyc;
	bit       quiet;
	bit       hold_tx;
	bit       in_acc;

	function automatic logic [31:0] rotl32(logic [31:0] x, int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] blk_mix(logic [31:0] k);
		k = k * MM_C1;
		k = rotl32(k, 15);
		return k * MM_C2;
	endfunction

	function automatic logic [31:0] fmix32(logic [31:0] h);
		h = h ^ (h >> 16);
		h = h * MM_F1;
		h = h ^ (h >> 13);
		h = h * MM_F2;
		return h ^ (h >> 16);
	endfunction

	task automatic clear_key_state();
		for (int i = 0; i < MAX_HASHES; i++) lane_hash[i] = i;
		tail_acc = '0;
		key_len = 0;
		key_ovf = 0;
	endtask

	// Advance the filter model by one byte; queue a verdict on the last byte
	task automatic filter_predict(bfm_in_t b);
		int unsigned k, rng, pos, idx;
		logic [31:0] kb, h;
		bfm_out_t v;
		if (key_ovf || key_len >= MAX_KEY_BYTES) begin
			key_ovf = 1;
		end else begin
			pos = key_len & 3;
			tail_acc = tail_acc | (32'(b.key_byte) << (8 * pos));
			key_len++;
			if (pos == 3) begin
				kb = blk_mix(tail_acc);
				for (int i = 0; i < MAX_HASHES; i++) begin
					h = rotl32(lane_hash[i] ^ kb, 13);
					lane_hash[i] = h * 5 + MM_N;
				end
				tail_acc = '0;
			end
		end
		if (!b.last) return;
		v.was_test = b.cmd;
		v.key_too_long = key_ovf;
		v.present = 1'b0;
		if (!key_ovf) begin
			k = (hash_cnt > MAX_HASHES) ? MAX_HASHES : hash_cnt;
			rng = idx_range;
			if (rng == 0) rng = 1;
			if (rng > FILTER_BITS) rng = FILTER_BITS;
			v.present = 1'b1;
			for (int i = 0; i < k; i++) begin
				h = lane_hash[i];
				if ((key_len & 3) != 0) h = h ^ blk_mix(tail_acc);
				h = fmix32(h ^ key_len);
				idx = h % rng;
				if (!b.cmd) filt_bits[idx] = 1;
				else if (!filt_bits[idx]) v.present = 1'b0;
			end
			if (!b.cmd) v.present = 1'b0;
		end
		verdict_q = {verdict_q, v};
		clear_key_state();
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cyc);
		n_errors++;
	endtask

	// Input transfer seen at the rising edge
	always @(posedge clk) begin
		in_acc <= arst_n && in_valid && in_ready;
	end

	// Driver: predicts each byte as its transfer completes
	int gap_in;
	always @(negedge clk) begin
		if (in_acc) begin
			filter_predict(in_data);
			void'(byte_q.pop_front());
		end
		if (byte_q.size() == 0 || hold_tx) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_acc) begin
			in_valid <= 1'b1;
		end else if (!quiet && gap_in > 0) begin
			gap_in <= gap_in - 1;
			in_valid <= 1'b0;
		end else begin
			if (!quiet && $urandom_range(0, 9) == 0) gap_in <= $urandom_range(1, 15);
			in_valid <= 1'b1;
			in_data <= byte_q[0];
		end
	end

	// Receiver stalls
	int gap_out;
	always @(negedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (gap_out > 0) begin
			gap_out <= gap_out - 1;
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 7) == 0) gap_out <= $urandom_range(1, 15);
			out_ready <= 1'b1;
		end
	end

	// Monitor: compare each result transfer with the oldest verdict
	bfm_out_t want;
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = verdict_q.pop_front();
				n_keys <= n_keys + 1;
				if (out_data.present !== want.present)
					report_mismatch("present", out_data.present, want.present);
				if (out_data.was_test !== want.was_test)
					report_mismatch("was_test", out_data.was_test, want.was_test);
				if (out_data.key_too_long !== want.key_too_long)
					report_mismatch("key_too_long", out_data.key_too_long,
						want.key_too_long);
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		if (cyc > 1500000) begin
			$display("timeout");
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic add_key(bit cmd, int len, int fill);
		bfm_in_t b;
		for (int i = 0; i < len; i++) begin
			b.cmd = (i == len - 1) ? cmd : 1'($urandom);
			b.key_byte = (fill >= 0) ? 8'(fill) : 8'($urandom);
			b.last = (i == len - 1);
			byte_q = {byte_q, b};
		end
	endtask

	task automatic drain();
		while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [16:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NUM_HASHES) hash_cnt = val[3:0];
		else idx_range = val;
	endtask

	// Random phase: mostly short keys, some long and oversized ones
	task automatic random_keys(int n_bytes);
		int len, r;
		while (n_bytes > 0) begin
			r = $urandom_range(0, 99);
			if (r < 80) len = $urandom_range(1, 12);
			else if (r < 95) len = $urandom_range(13, 40);
			else len = $urandom_range(250, 262);
			add_key($urandom_range(0, 1), len, -1);
			n_bytes -= len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_NUM_HASHES;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		n_errors = 0;
		n_keys = 0;
		cyc = 0;
		quiet = 0;
		hold_tx = 0;
		gap_in = 0;
		gap_out = 0;
		hash_cnt = 4'd3;
		idx_range = 17'd65536;
		foreach (filt_bits[i]) filt_bits[i] = 0;
		clear_key_state();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings, byte extremes, every tail length, long keys
		add_key(1, 1, 8'h00);
		add_key(0, 1, 8'hff);
		add_key(1, 1, 8'hff);
		for (int n = 2; n <= 9; n++) add_key(n & 1, n, -1);
		add_key(0, 4, 8'haa);
		add_key(1, 4, 8'haa);
		add_key(0, 256, -1);
		add_key(1, 257, -1);
		add_key(0, 300, 8'h55);
		// pause the sender until every result is in
		while (byte_q.size() != 0) @(posedge clk);
		hold_tx = 1;
		drain();
		hold_tx = 0;
		add_key(1, 3, 8'h00);
		add_key(0, 5, -1);
		drain();

		// Extremes of both registers, including out-of-range values
		write_reg(REG_NUM_HASHES, 17'd0);
		write_reg(REG_INDEX_RANGE, 17'd0);
		add_key(1, 3, -1);
		add_key(0, 3, -1);
		add_key(1, 2, -1);
		drain();
		write_reg(REG_NUM_HASHES, 17'd15);
		write_reg(REG_INDEX_RANGE, 17'h1ffff);
		random_keys(90);
		drain();
		write_reg(REG_NUM_HASHES, 17'd1);
		write_reg(REG_INDEX_RANGE, 17'd1);
		add_key(1, 2, -1);
		add_key(0, 2, -1);
		add_key(1, 6, -1);
		drain();
		write_reg(REG_NUM_HASHES, 17'd8);
		write_reg(REG_INDEX_RANGE, 17'd64);
		random_keys(140);
		drain();
		write_reg(REG_NUM_HASHES, 17'd2);
		write_reg(REG_INDEX_RANGE, 17'd1000);
		random_keys(140);
		drain();
		write_reg(REG_NUM_HASHES, 17'd5);
		write_reg(REG_INDEX_RANGE, 17'd65536);
		random_keys(150);
		drain();
		// last stretch without any idling
		quiet = 1;
		write_reg(REG_NUM_HASHES, 17'd4);
		write_reg(REG_INDEX_RANGE, 17'd300);
		random_keys(90);
		drain();

		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
